// ----- src/mi3_pkg.sv -----
// Shared constants and index helpers for the 3x3 matrix inverse core.
// No dependencies; used by every module of the block except mi3_div_lane.
`default_nettype none
package mi3_pkg;

  localparam int unsigned MatDim = 3;
  localparam int unsigned Lanes  = MatDim * MatDim;

  // Lower and upper of the two rows (or columns) that remain when one is struck out.
  function automatic int other_lo(input int idx);
    return (idx == 0) ? 1 : 0;
  endfunction

  function automatic int other_hi(input int idx);
    return (idx == 2) ? 1 : 2;
  endfunction

endpackage
`default_nettype wire

// ----- src/matrix3x3_inverse_core.sv -----
// Top level of the 3x3 fixed-point matrix inverse: cofactors, determinant,
// nine divider lanes and the saturating output stage. Depends on mi3_pkg,
// mi3_cofactor, mi3_det and mi3_div_lane.
//
//   Channel   Handshake                 Payload
//   input     in_valid_i / in_ready_o   a00_i .. a22_i
//   output    out_valid_o / out_ready_i b00_o .. b22_o, singular_o
//
// A new matrix may enter in every cycle while no result is held at the output.
// The divider lanes resolve one quotient bit per stage.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
// When a result waits at the output, the whole pipeline holds and in_ready_o falls.
`default_nettype none
module matrix3x3_inverse_core #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [ELEM_WIDTH-1:0]   a00_i,
  input  wire logic [ELEM_WIDTH-1:0]   a01_i,
  input  wire logic [ELEM_WIDTH-1:0]   a02_i,
  input  wire logic [ELEM_WIDTH-1:0]   a10_i,
  input  wire logic [ELEM_WIDTH-1:0]   a11_i,
  input  wire logic [ELEM_WIDTH-1:0]   a12_i,
  input  wire logic [ELEM_WIDTH-1:0]   a20_i,
  input  wire logic [ELEM_WIDTH-1:0]   a21_i,
  input  wire logic [ELEM_WIDTH-1:0]   a22_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [ELEM_WIDTH-1:0]        b00_o,
  output logic [ELEM_WIDTH-1:0]        b01_o,
  output logic [ELEM_WIDTH-1:0]        b02_o,
  output logic [ELEM_WIDTH-1:0]        b10_o,
  output logic [ELEM_WIDTH-1:0]        b11_o,
  output logic [ELEM_WIDTH-1:0]        b12_o,
  output logic [ELEM_WIDTH-1:0]        b20_o,
  output logic [ELEM_WIDTH-1:0]        b21_o,
  output logic [ELEM_WIDTH-1:0]        b22_o,
  output logic                         singular_o
);

  localparam int unsigned W   = ELEM_WIDTH;
  localparam int unsigned Lat = W + 6;

  logic                 en;
  logic [Lat-1:0]       vld_q;
  logic signed [W-1:0]  a    [mi3_pkg::Lanes];
  logic signed [2*W:0]  cof1 [mi3_pkg::Lanes];
  logic signed [2*W:0]  cof2 [mi3_pkg::Lanes];
  logic signed [W-1:0]  row0 [mi3_pkg::MatDim];
  logic signed [3*W+2:0] det;
  logic [W-1:0]         quo  [mi3_pkg::Lanes];
  logic                 neg  [mi3_pkg::Lanes];
  logic                 big  [mi3_pkg::Lanes];
  logic                 zero [mi3_pkg::Lanes];
  logic [W-1:0]         res_d [mi3_pkg::Lanes];
  logic [W-1:0]         res_q [mi3_pkg::Lanes];
  logic                 sing_q;

  // One enable for every stage: the pipeline moves unless a result is stuck at the output.
  assign en         = !vld_q[Lat-1] || out_ready_i;
  assign in_ready_o = en;

  assign a[0] = a00_i;
  assign a[1] = a01_i;
  assign a[2] = a02_i;
  assign a[3] = a10_i;
  assign a[4] = a11_i;
  assign a[5] = a12_i;
  assign a[6] = a20_i;
  assign a[7] = a21_i;
  assign a[8] = a22_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  mi3_cofactor #(.ELEM_WIDTH(W)) u_cofactor (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (a),
    .cof_o  (cof1),
    .row0_o (row0)
  );

  mi3_det #(.ELEM_WIDTH(W)) u_det (
    .clk_i  (clk_i),
    .en_i   (en),
    .cof_i  (cof1),
    .row0_i (row0),
    .cof_o  (cof2),
    .det_o  (det)
  );

  // Lane at output position (r, c) divides cofactor (c, r): the transpose forms the adjugate.
  for (genvar r = 0; r < 3; r++) begin : g_lane_r
    for (genvar c = 0; c < 3; c++) begin : g_lane_c
      mi3_div_lane #(.FRAC_BITS(FRAC_BITS), .ELEM_WIDTH(W)) u_lane (
        .clk_i  (clk_i),
        .en_i   (en),
        .adj_i  (cof2[c*3+r]),
        .det_i  (det),
        .quo_o  (quo[r*3+c]),
        .neg_o  (neg[r*3+c]),
        .big_o  (big[r*3+c]),
        .zero_o (zero[r*3+c])
      );
    end
  end

  // Merge: saturate each magnitude to the signed range, apply the sign; zero if singular.
  always_comb begin
    for (int k = 0; k < mi3_pkg::Lanes; k++) begin
      logic [W:0] lim;
      logic [W:0] mag;
      lim = neg[k] ? ((W+1)'(1) << (W-1)) : (((W+1)'(1) << (W-1)) - (W+1)'(1));
      mag = (big[k] || ({1'b0, quo[k]} > lim)) ? lim : {1'b0, quo[k]};
      res_d[k] = neg[k] ? W'(-mag) : W'(mag);
      if (zero[0]) begin
        res_d[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < mi3_pkg::Lanes; k++) begin
        res_q[k] <= res_d[k];
      end
      sing_q <= zero[0];
    end
  end

  assign out_valid_o = vld_q[Lat-1];
  assign b00_o = res_q[0];
  assign b01_o = res_q[1];
  assign b02_o = res_q[2];
  assign b10_o = res_q[3];
  assign b11_o = res_q[4];
  assign b12_o = res_q[5];
  assign b20_o = res_q[6];
  assign b21_o = res_q[7];
  assign b22_o = res_q[8];
  assign singular_o = sing_q;

  // A singular result carries zero elements; the check covers b00, b11, b22, b01, b12 and b20.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> (b00_o == '0) && (b11_o == '0) && (b22_o == '0)
      && (b01_o == '0) && (b12_o == '0) && (b20_o == '0))
    else $error("singular result with nonzero elements");

  // Back-pressure arises only from a held result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a held result");

  // An accepted transfer enters the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted matrix lost at pipeline entry");

  // A held result keeps the whole pipeline frozen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(vld_q))
    else $error("pipeline moved while output stalled");

endmodule
`default_nettype wire

// ----- src/mi3_cofactor.sv -----
// Two-stage cofactor unit: eighteen minor products, then nine signed cofactors.
// Depends on mi3_pkg for the matrix size and minor index helpers.
`default_nettype none
module mi3_cofactor #(
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  wire                           clk_i,
  input  wire                           en_i,
  input  wire logic signed [ELEM_WIDTH-1:0]   a_i   [mi3_pkg::Lanes],
  output logic signed [2*ELEM_WIDTH:0]        cof_o [mi3_pkg::Lanes],
  output logic signed [ELEM_WIDTH-1:0]        row0_o [mi3_pkg::MatDim]
);

  localparam int unsigned W = ELEM_WIDTH;

  logic signed [2*W-1:0] p1_q [mi3_pkg::Lanes];
  logic signed [2*W-1:0] p2_q [mi3_pkg::Lanes];
  logic signed [2*W-1:0] p1_d [mi3_pkg::Lanes];
  logic signed [2*W-1:0] p2_d [mi3_pkg::Lanes];
  logic signed [2*W:0]   cof_d [mi3_pkg::Lanes];
  logic signed [W-1:0]   row_q [mi3_pkg::MatDim];

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      localparam int R1 = mi3_pkg::other_lo(r);
      localparam int R2 = mi3_pkg::other_hi(r);
      localparam int C1 = mi3_pkg::other_lo(c);
      localparam int C2 = mi3_pkg::other_hi(c);
      localparam int K  = r * 3 + c;
      assign p1_d[K] = a_i[R1*3+C1] * a_i[R2*3+C2];
      assign p2_d[K] = a_i[R1*3+C2] * a_i[R2*3+C1];
      // Odd positions of the checkerboard take the negated minor.
      if (((r + c) % 2) == 1) begin : g_odd
        assign cof_d[K] = (2*W+1)'(p2_q[K]) - (2*W+1)'(p1_q[K]);
      end else begin : g_even
        assign cof_d[K] = (2*W+1)'(p1_q[K]) - (2*W+1)'(p2_q[K]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < mi3_pkg::Lanes; k++) begin
        p1_q[k]  <= p1_d[k];
        p2_q[k]  <= p2_d[k];
        cof_o[k] <= cof_d[k];
      end
      for (int j = 0; j < mi3_pkg::MatDim; j++) begin
        row_q[j]  <= a_i[j];
        row0_o[j] <= row_q[j];
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/mi3_det.sv -----
// Two-stage determinant unit: split partial products along row 0, then their sum.
// Also delays the cofactors to stay aligned. Depends on mi3_pkg.
`default_nettype none
module mi3_det #(
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  wire                                 clk_i,
  input  wire                                 en_i,
  input  wire logic signed [2*ELEM_WIDTH:0]   cof_i  [mi3_pkg::Lanes],
  input  wire logic signed [ELEM_WIDTH-1:0]   row0_i [mi3_pkg::MatDim],
  output logic signed [2*ELEM_WIDTH:0]        cof_o  [mi3_pkg::Lanes],
  output logic signed [3*ELEM_WIDTH+2:0]      det_o
);

  localparam int unsigned W  = ELEM_WIDTH;
  localparam int unsigned DW = 3 * W + 3;

  logic signed [2*W:0]   lo_q [mi3_pkg::MatDim];
  logic signed [2*W:0]   hi_q [mi3_pkg::MatDim];
  logic signed [2*W:0]   lo_d [mi3_pkg::MatDim];
  logic signed [2*W:0]   hi_d [mi3_pkg::MatDim];
  logic signed [2*W:0]   cof_q [mi3_pkg::Lanes];
  logic signed [DW-1:0]  det_d;

  // Each row-0 cofactor is split into an unsigned low word and a signed high part.
  for (genvar j = 0; j < 3; j++) begin : g_pp
    assign lo_d[j] = row0_i[j] * $signed({1'b0, cof_i[j][W-1:0]});
    assign hi_d[j] = row0_i[j] * $signed(cof_i[j][2*W:W]);
  end

  always_comb begin
    det_d = '0;
    for (int j = 0; j < 3; j++) begin
      det_d = det_d + (DW'(hi_q[j]) <<< W) + DW'(lo_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        lo_q[j] <= lo_d[j];
        hi_q[j] <= hi_d[j];
      end
      for (int k = 0; k < mi3_pkg::Lanes; k++) begin
        cof_q[k] <= cof_i[k];
        cof_o[k] <= cof_q[k];
      end
      det_o <= det_d;
    end
  end

endmodule
`default_nettype wire

// ----- src/mi3_div_lane.sv -----
// One divider lane: sign handling, range check and a pipelined restoring divider
// that yields one quotient bit per stage. No package dependencies.
`default_nettype none
module mi3_div_lane #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  wire                               clk_i,
  input  wire                               en_i,
  input  wire logic signed [2*ELEM_WIDTH:0] adj_i,
  input  wire logic signed [3*ELEM_WIDTH+2:0] det_i,
  output logic [ELEM_WIDTH-1:0]             quo_o,
  output logic                              neg_o,
  output logic                              big_o,
  output logic                              zero_o
);

  localparam int unsigned W  = ELEM_WIDTH;
  localparam int unsigned DW = 3 * W + 3;
  localparam int unsigned NW = 2 * W + 1 + 2 * FRAC_BITS;
  localparam int unsigned RW = ((NW - W) > (DW + 1)) ? (NW - W) : (DW + 1);
  localparam int unsigned CW = (NW > (DW + W)) ? NW : (DW + W);

  logic [2*W:0]  amag;
  logic [DW-1:0] dmag;
  logic [NW-1:0] num;
  logic          big_d;

  logic [RW-1:0] rem_q  [W+1];
  logic [RW-1:0] rem_d  [W+1];
  logic [W-1:0]  nlo_q  [W+1];
  logic [W-1:0]  quo_q  [W+1];
  logic [W-1:0]  quo_d  [W+1];
  logic [DW-1:0] dmag_q [W+1];
  logic          neg_q  [W+1];
  logic          big_q  [W+1];
  logic          zero_q [W+1];
  logic [RW-1:0] trial  [W];

  assign amag  = adj_i[2*W] ? (2*W+1)'(-adj_i) : (2*W+1)'(adj_i);
  assign dmag  = det_i[DW-1] ? DW'(-det_i) : DW'(det_i);
  assign num   = NW'(amag) << (2 * FRAC_BITS);
  // The quotient needs more than W bits when num >= dmag * 2^W.
  assign big_d = CW'(num) >= (CW'(dmag) << W);

  always_comb begin
    rem_d[0] = RW'(num[NW-1:W]);
    quo_d[0] = '0;
    for (int s = 0; s < W; s++) begin
      trial[s]   = RW'({rem_q[s], nlo_q[s][W-1]});
      if (trial[s] >= RW'(dmag_q[s])) begin
        rem_d[s+1] = trial[s] - RW'(dmag_q[s]);
        quo_d[s+1] = {quo_q[s][W-2:0], 1'b1};
      end else begin
        rem_d[s+1] = trial[s];
        quo_d[s+1] = {quo_q[s][W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rem_d[0];
      nlo_q[0]  <= num[W-1:0];
      quo_q[0]  <= quo_d[0];
      dmag_q[0] <= dmag;
      neg_q[0]  <= adj_i[2*W] ^ det_i[DW-1];
      big_q[0]  <= big_d;
      zero_q[0] <= (det_i == '0);
      for (int s = 0; s < W; s++) begin
        rem_q[s+1]  <= rem_d[s+1];
        nlo_q[s+1]  <= {nlo_q[s][W-2:0], 1'b0};
        quo_q[s+1]  <= quo_d[s+1];
        dmag_q[s+1] <= dmag_q[s];
        neg_q[s+1]  <= neg_q[s];
        big_q[s+1]  <= big_q[s];
        zero_q[s+1] <= zero_q[s];
      end
    end
  end

  assign quo_o  = quo_q[W];
  assign neg_o  = neg_q[W];
  assign big_o  = big_q[W];
  assign zero_o = zero_q[W];

endmodule
`default_nettype wire
